// ===== sv/csi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_pkg: shared types and constants of the chirp test-signal injector
// Holds the state codes, clamp limits and the sine table generator.
// ----------------------------------------------------------------------------
package csi_pkg;

	localparam int SineLutDepthDefault = 1024;

	localparam logic [2:0] ST_OFF  = 3'd0;
	localparam logic [2:0] ST_WAIT = 3'd1;
	localparam logic [2:0] ST_INIT = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [25:0] DUR_MIN = 26'd655;
	localparam logic [25:0] DUR_MAX = 26'd65536000;

	localparam logic [2:0] CFG_SWEEP_MODE = 3'd0;
	localparam logic [2:0] CFG_TARGET     = 3'd1;
	localparam logic [2:0] CFG_DURATION   = 3'd2;
	localparam logic [2:0] CFG_FREQ_BEGIN = 3'd3;
	localparam logic [2:0] CFG_FREQ_END   = 3'd4;
	localparam logic [2:0] CFG_FREQ_RAMP  = 3'd5;
	localparam logic [2:0] CFG_AMP_BEGIN  = 3'd6;
	localparam logic [2:0] CFG_AMP_END    = 3'd7;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Command and status between sequencer and arithmetic unit
	typedef struct packed {
		logic        start;
		logic [16:0] pct;
		logic [15:0] ramp;
	} pow_cmd_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [16:0] result;
	} pow_sts_t;

	// Sine table entry, Q1.16 signed, evaluated at elaboration
	function automatic logic signed [17:0] sine_entry(input int unsigned i, input int depth);
		logic [31:0] a;
		logic [1:0]  quad;
		logic [63:0] r;
		logic [63:0] th;
		logic [63:0] term;
		logic [63:0] s;
		logic signed [63:0] sum;
		a = 32'((64'(i) << 32) / 64'(depth));
		quad = a[31:30];
		r = 64'(a[29:0]);
		if (quad[0])
			r = Q30_ONE - r;
		th = (r * HALF_PI_Q30) >> 30;
		term = th;
		sum = $signed(th);
		for (int k = 1; k <= 7; k++) begin
			term = (((term * th) >> 30) * th) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		if (sum < 0)
			sum = 0;
		s = (64'(sum) + 64'd8192) >> 14;
		if (s > 64'd65536)
			s = 64'd65536;
		return quad[1] ? -$signed(18'(s)) : $signed(18'(s));
	endfunction

endpackage

// ===== sv/chirp_test_signal_injector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chirp_test_signal_injector: frequency-sweep test signal generator
// Tick beats run the off/wait/init/running/complete sequencer; sample beats at
// the injection point are gain-scaled and get the current test signal added.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (valid/ready): func selects a tick (0) or a sample (1).
//   Output channel (valid/ready): one result beat per input beat.
//   Config channel (valid/ready): register index and data; write only when
//   the block is idle.
// Sequence: a sample beat or a non-sweep tick goes from acceptance to the out
//   step (through the injection step first when injected) and, once the output
//   register is free, into it; the next beat can then be accepted. A sweep tick
//   runs the divider, integer power products, a root and a multiply for each
//   of the twelve fraction bits, then the frequency, phase and signal steps.
// Throughput: one beat in work at a time; in_ready is low until it is done.
// Reset: sequencer goes to off, time, phase, signal, gain and report clear,
//   registers take their reset values.
// Stall: a finished result waits in the output register until taken; the
//   next beat is accepted and worked on meanwhile, and its result holds in
//   the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module chirp_test_signal_injector #(
	parameter int SINE_LUT_DEPTH = csi_pkg::SineLutDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [25:0]        cfg_data,
	// input beat
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [15:0]        step_time,
	input  logic               enable_flag,
	input  logic signed [23:0] gain_in,
	input  logic [7:0]         main_mode,
	input  logic [7:0]         nav_mode,
	input  logic [7:0]         sample_point,
	input  logic signed [23:0] sample_value,
	// result beat
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         fsm_state,
	output logic signed [23:0] raw_signal,
	output logic [16:0]        time_pct,
	output logic signed [23:0] cur_amp,
	output logic [23:0]        cur_freq,
	output logic signed [23:0] sample_out,
	output logic               was_injected
);
	import csi_pkg::*;

	localparam int IDX_W = $clog2(SINE_LUT_DEPTH);

	// sine table as constant logic, read through a register
	logic signed [17:0] sine_rom [SINE_LUT_DEPTH];
	for (genvar g = 0; g < SINE_LUT_DEPTH; g++) begin : g_rom
		assign sine_rom[g] = sine_entry(g, SINE_LUT_DEPTH);
	end

	// sequencer step codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_POW  = 3'd2;
	localparam logic [2:0] S_FRQ  = 3'd3;
	localparam logic [2:0] S_PHS  = 3'd4;
	localparam logic [2:0] S_SIG  = 3'd5;
	localparam logic [2:0] S_INJ  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	// configuration registers
	logic [1:0]         sweep_mode_q;
	logic [7:0]         target_q;
	logic [25:0]        duration_q;
	logic [23:0]        fbeg_q, fend_q;
	logic [15:0]        ramp_q;
	logic signed [23:0] abeg_q, aend_q;

	// block state
	logic [2:0]         st_q;
	logic [31:0]        elapsed_q;
	logic [31:0]        phase_q;
	logic signed [23:0] hold_q;
	logic signed [23:0] gain_q;
	logic [7:0]         smain_q, snav_q;
	logic [16:0]        rpct_q;
	logic signed [23:0] ramp_amp_q;
	logic [23:0]        rfreq_q;

	// working registers
	logic [2:0]         seq_q;
	logic [15:0]        dt_q;
	logic signed [23:0] smp_q;
	logic [16:0]        pct_q;
	logic signed [23:0] amp_q;
	logic signed [23:0] res_q;
	logic               inj_q;
	logic               out_valid_q;
	logic               div_start_q;
	logic signed [17:0] sine_q;

	// output register
	logic [2:0]         ost_q;
	logic signed [23:0] oraw_q;
	logic [16:0]        opct_q;
	logic signed [23:0] oamp_q;
	logic [23:0]        ofreq_q;
	logic signed [23:0] osout_q;
	logic               oinj_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (seq_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_mode_q <= '0;
			target_q     <= '0;
			duration_q   <= 26'd655360;
			fbeg_q       <= 24'd65536;
			fend_q       <= 24'd655360;
			ramp_q       <= 16'd4096;
			abeg_q       <= '0;
			aend_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SWEEP_MODE: sweep_mode_q <= cfg_data[1:0];
				CFG_TARGET:     target_q     <= cfg_data[7:0];
				CFG_DURATION:   duration_q   <= cfg_data;
				CFG_FREQ_BEGIN: fbeg_q       <= cfg_data[23:0];
				CFG_FREQ_END:   fend_q       <= cfg_data[23:0];
				CFG_FREQ_RAMP:  ramp_q       <= cfg_data[15:0];
				CFG_AMP_BEGIN:  abeg_q       <= cfg_data[23:0];
				default:        aend_q       <= cfg_data[23:0];
			endcase
		end
	end

	// clamped divisor
	logic [25:0] dclamp;
	assign dclamp = (duration_q < DUR_MIN) ? DUR_MIN
		: ((duration_q > DUR_MAX) ? DUR_MAX : duration_q);

	logic        div_done;
	logic [16:0] div_q;
	csi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .elapsed(elapsed_q),
		.divisor(dclamp), .done(div_done), .quot(div_q)
	);

	pow_cmd_t pcmd;
	pow_sts_t psts;
	logic     pow_start_q;
	assign pcmd.start = pow_start_q;
	assign pcmd.pct   = pct_q;
	assign pcmd.ramp  = ramp_q;
	csi_pow u_pow (.clk(clk), .arst_n(arst_n), .cmd(pcmd), .sts(psts));

	// amplitude from pct: ab + floor((ae-ab)*pct/2^16)
	logic signed [24:0] adiff;
	logic signed [42:0] aprod;
	logic signed [26:0] asum;
	assign adiff = 25'(aend_q) - 25'(abeg_q);
	assign aprod = 43'(adiff) * $signed({26'd0, pct_q});
	assign asum  = 27'(abeg_q) + 27'(aprod >>> 16);

	// frequency from power result
	logic signed [24:0] fdiff;
	logic signed [42:0] fprod;
	logic signed [26:0] fsum;
	assign fdiff = $signed({1'b0, fend_q}) - $signed({1'b0, fbeg_q});
	assign fprod = 43'(fdiff) * $signed({26'd0, psts.result});
	assign fsum  = $signed({3'd0, fbeg_q}) + 27'(fprod >>> 16);

	// phase advance and signal; the table is read at the new phase
	logic [39:0]        fdt;
	logic [31:0]        phase_nx;
	logic [IDX_W-1:0]   sidx;
	logic signed [41:0] sprod;
	logic signed [25:0] ssh;
	assign fdt      = 40'(rfreq_q) * 40'(dt_q);
	assign phase_nx = phase_q + fdt[31:0];
	assign sidx     = phase_nx[31 -: IDX_W];
	assign sprod    = 42'(amp_q) * 42'(sine_q);
	assign ssh      = 26'(sprod >>> 16);

	always_ff @(posedge clk) begin
		sine_q <= sine_rom[sidx];
	end

	// injection
	logic signed [47:0] iprod;
	logic signed [33:0] isum;
	assign iprod = 48'(smp_q) * 48'(gain_q);
	assign isum  = 34'(iprod >>> 16) + 34'(hold_q);

	logic [32:0] el_sum;
	assign el_sum = 33'(elapsed_q) + 33'(dt_q);

	// sample hits the injection point while running
	logic hit;
	assign hit = (st_q == ST_RUN) && (sample_point == target_q);

	// running tick that computes a new sweep point
	logic sweep_go;
	assign sweep_go = (st_q == ST_RUN) && (main_mode == smain_q) && (nav_mode == snav_q)
		&& enable_flag && (sweep_mode_q == 2'd0) && !(elapsed_q > 32'(duration_q));

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// load the output register when it is free or being emptied
	logic out_load;
	assign out_load = (seq_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_IDLE;
			st_q        <= ST_OFF;
			elapsed_q   <= '0;
			phase_q     <= '0;
			hold_q      <= '0;
			gain_q      <= '0;
			smain_q     <= '0;
			snav_q      <= '0;
			rpct_q      <= '0;
			ramp_amp_q  <= '0;
			rfreq_q     <= '0;
			div_start_q <= 1'b0;
			pow_start_q <= 1'b0;
			res_q       <= '0;
			inj_q       <= 1'b0;
			dt_q        <= '0;
			smp_q       <= '0;
			pct_q       <= '0;
			amp_q       <= '0;
		end else begin
			div_start_q <= in_acc && !func && sweep_go;
			pow_start_q <= (seq_q == S_DIV) && div_done;
			unique case (seq_q)
				S_IDLE: begin
					if (in_acc) begin
						dt_q  <= step_time;
						smp_q <= sample_value;
						res_q <= func ? sample_value : '0;
						inj_q <= func && hit;
						if (func) begin
							seq_q <= hit ? S_INJ : S_OUT;
						end else begin
							seq_q <= sweep_go ? S_DIV : S_OUT;
							unique case (st_q)
								ST_OFF: st_q <= ST_WAIT;
								ST_WAIT: begin
									if (enable_flag) begin
										gain_q <= gain_in;
										st_q   <= ST_INIT;
									end
								end
								ST_INIT: begin
									smain_q   <= main_mode;
									snav_q    <= nav_mode;
									elapsed_q <= '0;
									phase_q   <= '0;
									hold_q    <= '0;
									st_q      <= ST_RUN;
								end
								ST_RUN: begin
									if (main_mode == smain_q && nav_mode == snav_q
										&& enable_flag && sweep_mode_q <= 2'd1) begin
										if (sweep_mode_q == 2'd0) begin
											if (elapsed_q > 32'(duration_q)) begin
												st_q <= ST_DONE;
												elapsed_q <= el_sum[32] ? '1 : el_sum[31:0];
											end
										end else begin
											elapsed_q <= el_sum[32] ? '1 : el_sum[31:0];
										end
									end else begin
										st_q <= ST_DONE;
									end
								end
								default: begin
									hold_q     <= '0;
									rpct_q     <= '0;
									ramp_amp_q <= '0;
									rfreq_q    <= '0;
									if (!enable_flag)
										st_q <= ST_OFF;
								end
							endcase
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						pct_q <= div_q;
						seq_q <= S_POW;
					end
				end
				S_POW: begin
					amp_q <= (asum > 27'sd8388607) ? 24'sh7FFFFF
						: ((asum < -27'sd8388608) ? 24'sh800000 : 24'(asum));
					if (psts.done)
						seq_q <= S_FRQ;
				end
				S_FRQ: begin
					rfreq_q <= (fsum < 0) ? 24'd0
						: ((fsum > 27'sd16777215) ? 24'hFFFFFF : 24'(fsum));
					seq_q <= S_PHS;
				end
				S_PHS: begin
					phase_q <= phase_nx;
					seq_q   <= S_SIG;
				end
				S_SIG: begin
					hold_q <= (ssh > 26'sd8388607) ? 24'sh7FFFFF
						: ((ssh < -26'sd8388608) ? 24'sh800000 : 24'(ssh));
					rpct_q     <= pct_q;
					ramp_amp_q <= amp_q;
					elapsed_q  <= el_sum[32] ? '1 : el_sum[31:0];
					seq_q      <= S_OUT;
				end
				S_INJ: begin
					res_q <= (isum > 34'sd8388607) ? 24'sh7FFFFF
						: ((isum < -34'sd8388608) ? 24'sh800000 : 24'(isum));
					seq_q <= S_OUT;
				end
				default: begin
					if (out_load)
						seq_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register: capture the finished beat, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ost_q       <= '0;
			oraw_q      <= '0;
			opct_q      <= '0;
			oamp_q      <= '0;
			ofreq_q     <= '0;
			osout_q     <= '0;
			oinj_q      <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			ost_q       <= st_q;
			oraw_q      <= hold_q;
			opct_q      <= rpct_q;
			oamp_q      <= ramp_amp_q;
			ofreq_q     <= rfreq_q;
			osout_q     <= res_q;
			oinj_q      <= inj_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign fsm_state    = ost_q;
	assign raw_signal   = oraw_q;
	assign time_pct     = opct_q;
	assign cur_amp      = oamp_q;
	assign cur_freq     = ofreq_q;
	assign sample_out   = osout_q;
	assign was_injected = oinj_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q <= ST_DONE) else $error("bad sequencer state");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q) else $error("result dropped");
endmodule

// ===== sv/csi_pow.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_pow: iterative pct^ramp unit
// Integer power by repeated products, fraction bits by repeated bit-serial
// square roots, all on one shared multiplier and one root datapath.
// ----------------------------------------------------------------------------
module csi_pow (
	input  logic             clk,
	input  logic             arst_n,
	input  csi_pkg::pow_cmd_t cmd,
	output csi_pkg::pow_sts_t sts
);
	import csi_pkg::*;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_INT  = 2'd1;
	localparam logic [1:0] P_SQRT = 2'd2;
	localparam logic [1:0] P_MUL  = 2'd3;

	logic [1:0]  st_q;
	logic [3:0]  cnt_q;      // integer power count, then fraction bit index
	logic [11:0] frac_q;
	logic [31:0] x_q;        // Q2.30 base
	logic [31:0] acc_q;      // Q2.30 accumulator
	logic [31:0] s_q;        // current root
	logic [31:0] root_q;
	logic [4:0]  rbit_q;     // root bit position
	logic        done_q;

	// shared multiplier operand
	logic [31:0] mul_b;
	logic [63:0] prod;
	assign mul_b = (st_q == P_INT) ? x_q : root_q;
	assign prod = 64'(acc_q) * 64'(mul_b);

	// one restoring square-root step: radicand s<<30 is 62 bits, root 31 bits
	logic [63:0] trial;
	logic [31:0] cand;
	assign cand = root_q | (32'd1 << rbit_q);
	assign trial = 64'(cand) * 64'(cand);

	logic [61:0] rad_full;
	assign rad_full = {s_q[31:0], 30'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= P_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rbit_q <= '0;
		end else begin
			done_q <= (st_q == P_MUL) && (cnt_q == 4'd0);
			unique case (st_q)
				P_IDLE: begin
					if (cmd.start) begin
						s_q    <= 32'({cmd.pct, 14'd0});
						x_q    <= 32'({cmd.pct, 14'd0});
						acc_q  <= 32'(Q30_ONE);
						cnt_q  <= cmd.ramp[15:12];
						frac_q <= cmd.ramp[11:0];
						st_q   <= P_INT;
					end
				end
				P_INT: begin
					if (cnt_q != 4'd0) begin
						acc_q <= 32'(prod >> 30);
						cnt_q <= cnt_q - 4'd1;
					end else begin
						cnt_q  <= 4'd11;
						root_q <= '0;
						rbit_q <= 5'd30;
						st_q   <= P_SQRT;
					end
				end
				P_SQRT: begin
					if (64'(trial) <= 64'(rad_full))
						root_q <= cand;
					if (rbit_q == 5'd0) begin
						st_q <= P_MUL;
					end else begin
						rbit_q <= rbit_q - 5'd1;
					end
				end
				default: begin
					s_q <= root_q;
					if (frac_q[cnt_q])
						acc_q <= 32'(prod >> 30);
					if (cnt_q == 4'd0) begin
						st_q <= P_IDLE;
					end else begin
						cnt_q  <= cnt_q - 4'd1;
						root_q <= '0;
						rbit_q <= 5'd30;
						st_q   <= P_SQRT;
					end
				end
			endcase
		end
	end

	assign sts.busy   = (st_q != P_IDLE);
	assign sts.done   = done_q;
	assign sts.result = 17'(acc_q >> 14);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> st_q == P_IDLE) else $error("pow done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && st_q == P_IDLE) |=> st_q == P_INT) else $error("pow start lost");
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == P_SQRT |-> rbit_q <= 5'd30) else $error("root bit out of range");
endmodule

// ===== sv/csi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_div: restoring divider for the elapsed fraction
// One quotient bit a cycle; quotient of (elapsed<<16)/d saturated to 65536.
// ----------------------------------------------------------------------------
module csi_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] elapsed,
	input  logic [25:0] divisor,
	output logic        done,
	output logic [16:0] quot
);
	logic [47:0] num_q;
	logic [26:0] rem_q;
	logic [47:0] q_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [26:0] rem_sh;
	assign rem_sh = {rem_q[25:0], num_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start && !busy_q) begin
				num_q  <= {elapsed, 16'd0};
				rem_q  <= '0;
				q_q    <= '0;
				cnt_q  <= 6'd48;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= {num_q[46:0], 1'b0};
				if (rem_sh >= {1'b0, divisor}) begin
					rem_q <= rem_sh - {1'b0, divisor};
					q_q   <= {q_q[46:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					q_q   <= {q_q[46:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quot = (q_q > 48'd65536) ? 17'd65536 : q_q[16:0];
endmodule
